// ----- src/tcgr_pkg.sv -----
// shared types, constants and glyph table for the text cell glyph rasteriser
package tcgr_pkg;

  localparam int ScreenWidthDef  = 128;
  localparam int ScreenHeightDef = 128;

  localparam int CellW      = 4;
  localparam int CellH      = 8;
  localparam int GlyphCount = 13;
  localparam int GlyphW     = $clog2(GlyphCount);
  localparam int RowW       = $clog2(CellH);
  localparam int RowCntW    = $clog2(CellH + 1);
  localparam int ColorW     = 16;
  localparam int CodeW      = 8;
  localparam int CellCoordW = 5;
  localparam int ScrCoordW  = 7;
  localparam int CellYPixW  = CellCoordW + RowW;
  localparam int QueueDepth = 2;

  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_FOREGROUND = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_BACKGROUND = CfgIdxW'(1);

  localparam logic [ColorW-1:0] FgReset = 16'hFFFF;
  localparam logic [ColorW-1:0] BgReset = 16'h0000;

  localparam logic [CodeW-1:0] GlyphCodes [GlyphCount] = '{
    8'h20, 8'h2E, 8'h2C, 8'h2D, 8'h7E, 8'h3A, 8'h3B,
    8'h3D, 8'h21, 8'h2A, 8'h23, 8'h24, 8'h40
  };

  localparam logic [CellW-1:0] GlyphRows [GlyphCount][CellH] = '{
    '{4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0},
    '{4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h6, 4'h6},
    '{4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h6, 4'h6, 4'h4},
    '{4'h0, 4'h0, 4'h0, 4'h0, 4'hF, 4'h0, 4'h0, 4'h0},
    '{4'h0, 4'h0, 4'h0, 4'hA, 4'h5, 4'h0, 4'h0, 4'h0},
    '{4'h0, 4'h6, 4'h6, 4'h0, 4'h0, 4'h6, 4'h6, 4'h0},
    '{4'h0, 4'h6, 4'h6, 4'h0, 4'h0, 4'h6, 4'h6, 4'h4},
    '{4'h0, 4'h0, 4'hF, 4'h0, 4'hF, 4'h0, 4'h0, 4'h0},
    '{4'h4, 4'h4, 4'h4, 4'h4, 4'h4, 4'h0, 4'h4, 4'h0},
    '{4'h0, 4'hA, 4'hF, 4'hA, 4'h0, 4'h0, 4'h0, 4'h0},
    '{4'h0, 4'hA, 4'hF, 4'hA, 4'hF, 4'hA, 4'h0, 4'h0},
    '{4'h4, 4'h7, 4'hC, 4'h7, 4'h1, 4'hE, 4'h4, 4'h0},
    '{4'h6, 4'h9, 4'hB, 4'hB, 4'h8, 4'h7, 4'h0, 4'h0}
  };

  typedef struct packed {
    logic [GlyphW-1:0]    glyph;
    logic [ScrCoordW-1:0] x0;
    logic [CellYPixW-1:0] y0;
    logic [RowCntW-1:0]   nrows;
  } job_t;

  function automatic logic [CellW-1:0] glyph_row(logic [GlyphW-1:0] g,
                                                 logic [RowW-1:0] r);
    logic [CellW-1:0] bits;
    bits = '0;
    if (int'(g) < GlyphCount) begin
      bits = GlyphRows[g][r];
    end
    return bits;
  endfunction

endpackage

// ----- src/tcgr_if.sv -----
// channel interfaces: character input, row output and register writes
interface tcgr_in_if;
  logic                           valid;
  logic                           ready;
  logic [tcgr_pkg::CodeW-1:0]      char_code;
  logic [tcgr_pkg::CellCoordW-1:0] cell_x;
  logic [tcgr_pkg::CellCoordW-1:0] cell_y;
  modport source (output valid, char_code, cell_x, cell_y, input ready);
  modport sink (input valid, char_code, cell_x, cell_y, output ready);
endinterface

interface tcgr_out_if;
  logic                          valid;
  logic                          ready;
  logic [tcgr_pkg::ScrCoordW-1:0] row_x;
  logic [tcgr_pkg::ScrCoordW-1:0] row_y;
  logic [tcgr_pkg::ColorW-1:0]    col0_color;
  logic [tcgr_pkg::ColorW-1:0]    col1_color;
  logic [tcgr_pkg::ColorW-1:0]    col2_color;
  logic [tcgr_pkg::ColorW-1:0]    col3_color;
  logic                          last_row;
  modport source (output valid, row_x, row_y, col0_color, col1_color, col2_color,
                  col3_color, last_row, input ready);
  modport sink (input valid, row_x, row_y, col0_color, col1_color, col2_color,
                col3_color, last_row, output ready);
endinterface

interface tcgr_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tcgr_pkg::CfgIdxW-1:0] index;
  logic [tcgr_pkg::ColorW-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/tcgr_front.sv -----
// front end: accepts characters, picks the glyph and clips the cell to the screen
module tcgr_front #(
  parameter int SCREEN_WIDTH  = tcgr_pkg::ScreenWidthDef,
  parameter int SCREEN_HEIGHT = tcgr_pkg::ScreenHeightDef
) (
  tcgr_in_if.sink        in_i,
  input  logic           q_full_i,
  output logic           push_o,
  output tcgr_pkg::job_t job_o
);
  import tcgr_pkg::*;

  logic [GlyphW-1:0]    glyph;
  logic [ScrCoordW-1:0] x0;
  logic [CellYPixW-1:0] y0;
  int                   rem;
  logic                 visible;

  always_comb begin
    glyph = '0;
    for (int k = GlyphCount - 1; k >= 0; k--) begin
      if (in_i.char_code == GlyphCodes[k]) begin
        glyph = GlyphW'(k);
      end
    end
  end

  assign x0      = {in_i.cell_x, 2'b00};
  assign y0      = {in_i.cell_y, 3'b000};
  assign rem     = SCREEN_HEIGHT - int'(y0);
  assign visible = (int'(x0) < SCREEN_WIDTH) && (int'(y0) < SCREEN_HEIGHT);

  assign in_i.ready  = !q_full_i;
  assign push_o      = in_i.valid && !q_full_i && visible;
  assign job_o.glyph = glyph;
  assign job_o.x0    = x0;
  assign job_o.y0    = y0;
  assign job_o.nrows = (rem > CellH) ? RowCntW'(CellH) : RowCntW'(rem);

endmodule

// ----- src/tcgr_queue.sv -----
// small register queue of classified cells between front and back end
module tcgr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tcgr_pkg::job_t job_i,
  output logic           full_o,
  output logic           head_valid_o,
  output tcgr_pkg::job_t head_o,
  input  logic           pop_i
);
  import tcgr_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (int'(p) == QueueDepth - 1) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o       = (int'(cnt_q) == QueueDepth);
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// ----- src/tcgr_back.sv -----
// back end: walks the rows of the head cell and drives the registered row output
module tcgr_back #(
  parameter int SCREEN_WIDTH = tcgr_pkg::ScreenWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          head_valid_i,
  input  tcgr_pkg::job_t                head_i,
  output logic                          pop_o,
  input  logic [tcgr_pkg::ColorW-1:0]   fg_i,
  input  logic [tcgr_pkg::ColorW-1:0]   bg_i,
  tcgr_out_if.source                    out_o
);
  import tcgr_pkg::*;

  logic [RowW-1:0]      row_q, row_d;
  logic                 out_valid_q;
  logic [ScrCoordW-1:0] row_x_q, row_y_q;
  logic [ColorW-1:0]    col_q [CellW];
  logic [ColorW-1:0]    col_d [CellW];
  logic                 last_q;
  logic [CellW-1:0]     bits;
  logic                 last;
  logic                 load;

  assign bits = glyph_row(head_i.glyph, row_q);
  assign last = ({1'b0, row_q} + RowCntW'(1)) == head_i.nrows;
  assign load = head_valid_i && (!out_valid_q || out_o.ready);
  assign pop_o = load && last;
  assign row_d = last ? '0 : row_q + RowW'(1);

  always_comb begin
    for (int c = 0; c < CellW; c++) begin
      if (int'(head_i.x0) + c >= SCREEN_WIDTH) begin
        col_d[c] = '0;
      end else if (bits[CellW-1-c]) begin
        col_d[c] = fg_i;
      end else begin
        col_d[c] = bg_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        row_q       <= row_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      row_x_q <= head_i.x0;
      row_y_q <= ScrCoordW'(head_i.y0 + CellYPixW'(row_q));
      col_q   <= col_d;
      last_q  <= last;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.row_x      = row_x_q;
  assign out_o.row_y      = row_y_q;
  assign out_o.col0_color = col_q[0];
  assign out_o.col1_color = col_q[1];
  assign out_o.col2_color = col_q[2];
  assign out_o.col3_color = col_q[3];
  assign out_o.last_row   = last_q;

endmodule

// ----- src/text_cell_glyph_rasterizer_top.sv -----
// Text cell glyph rasteriser: each accepted character (code, text column, text row) is drawn
// as one of 13 built-in 4x8 shade glyphs and leaves as up to eight row transactions, top row
// first, each carrying four RGB565 pixels taken from the foreground and background colour
// registers (unknown codes draw blank). A visible cell leaves at one row per cycle while the
// output is not stalled, emitted by the back end from its output register; a cell clipped at
// the bottom edge gives only its visible rows, and a cell wholly off screen is accepted and
// gives nothing. The front end keeps accepting into a two-entry queue until it is full while
// the back end works or the output is stalled; the first row passes through the queue and
// then the output register before it is offered. Colour registers are written at index 0
// (foreground) and 1 (background) and should only change while the block is idle.
module text_cell_glyph_rasterizer_top #(
  parameter int SCREEN_WIDTH  = tcgr_pkg::ScreenWidthDef,
  parameter int SCREEN_HEIGHT = tcgr_pkg::ScreenHeightDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcgr_in_if.sink    in_i,
  tcgr_out_if.source out_o,
  tcgr_cfg_if.sink   cfg_i
);
  import tcgr_pkg::*;

  logic [ColorW-1:0] fg_q, bg_q;
  logic              push, q_full, head_valid, pop;
  job_t              push_job, head_job;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= FgReset;
      bg_q <= BgReset;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CFG_FOREGROUND) begin
        fg_q <= cfg_i.data;
      end else if (cfg_i.index == CFG_BACKGROUND) begin
        bg_q <= cfg_i.data;
      end
    end
  end

  tcgr_front #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_front (
    .in_i    (in_i),
    .q_full_i(q_full),
    .push_o  (push),
    .job_o   (push_job)
  );

  tcgr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .job_i       (push_job),
    .full_o      (q_full),
    .head_valid_o(head_valid),
    .head_o      (head_job),
    .pop_i       (pop)
  );

  tcgr_back #(
    .SCREEN_WIDTH(SCREEN_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head_job),
    .pop_o       (pop),
    .fg_i        (fg_q),
    .bg_i        (bg_q),
    .out_o       (out_o)
  );

endmodule

// ----- src/tcgr_checker.sv -----
// port-level checks for the text cell glyph rasteriser and their binding
module tcgr_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [tcgr_pkg::ScrCoordW-1:0] row_x,
  input logic [tcgr_pkg::ScrCoordW-1:0] row_y,
  input logic                           last_row
);

  // a stalled row stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("row dropped while stalled");

  // rows of one cell follow each other without a gap
  a_next_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !last_row |=>
      out_valid && (row_y == $past(row_y) + 7'd1) && (row_x == $past(row_x)))
    else $error("next row of cell missing or misplaced");

  // the bottom row of a cell always closes it
  a_bottom_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (row_y[2:0] == 3'd7) |-> last_row)
    else $error("bottom cell row not marked last");

  // rows start on a cell boundary
  a_x_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (row_x[1:0] == 2'd0))
    else $error("row x not cell aligned");

endmodule

bind text_cell_glyph_rasterizer_top tcgr_checker u_tcgr_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .out_valid(out_o.valid),
  .out_ready(out_o.ready),
  .row_x    (out_o.row_x),
  .row_y    (out_o.row_y),
  .last_row (out_o.last_row)
);

// ----- verif/text_cell_glyph_rasterizer_top_tb.sv -----
// testbench for the text cell glyph rasteriser: random characters and colours, rows predicted
`timescale 1ns / 1ps

module text_cell_glyph_rasterizer_top_tb;
  import tcgr_pkg::*;

  localparam int SCREEN_WIDTH  = ScreenWidthDef;
  localparam int SCREEN_HEIGHT = ScreenHeightDef;

  localparam int CycleLimit  = 400000;
  localparam int SettleTicks = 20;
  localparam int MaxWait     = 15;
  localparam int PhaseItems  = 50;
  localparam int NumPhases   = 8;
  localparam int TextRows    = SCREEN_HEIGHT / CellH;
  localparam int LastOnRow   = (TextRows > 32) ? 31 : TextRows - 1;

  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = CfgIdxW'(3);

  localparam logic [CodeW-1:0] ShadeChars [GlyphCount] = '{
    " ", ".", ",", "-", "~", ":", ";", "=", "!", "*", "#", "$", "@"
  };

  localparam logic [CellW-1:0] ShadeBitmaps [GlyphCount][CellH] = '{
    '{4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0},
    '{4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h6, 4'h6},
    '{4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 4'h6, 4'h6, 4'h4},
    '{4'h0, 4'h0, 4'h0, 4'h0, 4'hF, 4'h0, 4'h0, 4'h0},
    '{4'h0, 4'h0, 4'h0, 4'hA, 4'h5, 4'h0, 4'h0, 4'h0},
    '{4'h0, 4'h6, 4'h6, 4'h0, 4'h0, 4'h6, 4'h6, 4'h0},
    '{4'h0, 4'h6, 4'h6, 4'h0, 4'h0, 4'h6, 4'h6, 4'h4},
    '{4'h0, 4'h0, 4'hF, 4'h0, 4'hF, 4'h0, 4'h0, 4'h0},
    '{4'h4, 4'h4, 4'h4, 4'h4, 4'h4, 4'h0, 4'h4, 4'h0},
    '{4'h0, 4'hA, 4'hF, 4'hA, 4'h0, 4'h0, 4'h0, 4'h0},
    '{4'h0, 4'hA, 4'hF, 4'hA, 4'hF, 4'hA, 4'h0, 4'h0},
    '{4'h4, 4'h7, 4'hC, 4'h7, 4'h1, 4'hE, 4'h4, 4'h0},
    '{4'h6, 4'h9, 4'hB, 4'hB, 4'h8, 4'h7, 4'h0, 4'h0}
  };

  typedef struct packed {
    logic [ScrCoordW-1:0]         row_x;
    logic [ScrCoordW-1:0]         row_y;
    logic [CellW-1:0][ColorW-1:0] colour;
    logic                         last_row;
  } pixel_row_t;

  class glyph_row_scoreboard;
    pixel_row_t        awaited_rows[$];
    logic [ColorW-1:0] fg_colour;
    logic [ColorW-1:0] bg_colour;
    int                mismatches;

    function new();
      fg_colour  = FgReset;
      bg_colour  = BgReset;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [ColorW-1:0] data);
      case (idx)
        CFG_FOREGROUND: fg_colour = data;
        CFG_BACKGROUND: bg_colour = data;
        default: ;
      endcase
    endfunction

    // expands one accepted character into the rows it should produce
    function void draw_cell(logic [CodeW-1:0] code, logic [CellCoordW-1:0] cx,
                            logic [CellCoordW-1:0] cy);
      int               x0;
      int               y0;
      int               nrows;
      int               glyph;
      logic [CellW-1:0] bits;
      pixel_row_t       row;
      x0 = int'(cx) * CellW;
      y0 = int'(cy) * CellH;
      if (x0 >= SCREEN_WIDTH || y0 >= SCREEN_HEIGHT) return;
      nrows = SCREEN_HEIGHT - y0;
      if (nrows > CellH) nrows = CellH;
      glyph = 0;
      for (int k = 0; k < GlyphCount; k++) begin
        if (ShadeChars[k] == code) glyph = k;
      end
      for (int r = 0; r < nrows; r++) begin
        bits = ShadeBitmaps[glyph][r];
        row.row_x = ScrCoordW'(x0);
        row.row_y = ScrCoordW'(y0 + r);
        for (int c = 0; c < CellW; c++) begin
          row.colour[c] = bits[CellW-1-c] ? fg_colour : bg_colour;
          if (x0 + c >= SCREEN_WIDTH) row.colour[c] = '0;
        end
        row.last_row = (r == nrows - 1);
        awaited_rows.push_back(row);
      end
    endfunction

    function void check_row(pixel_row_t got);
      pixel_row_t exp;
      if (awaited_rows.size() == 0) begin
        $error("row transaction with nothing awaited: x %0d y %0d", got.row_x, got.row_y);
        mismatches++;
        return;
      end
      exp = awaited_rows.pop_front();
      if (got.row_x !== exp.row_x) begin
        $error("row_x: expected %0d, got %0d", exp.row_x, got.row_x);
        mismatches++;
      end
      if (got.row_y !== exp.row_y) begin
        $error("row_y: expected %0d, got %0d", exp.row_y, got.row_y);
        mismatches++;
      end
      for (int c = 0; c < CellW; c++) begin
        if (got.colour[c] !== exp.colour[c]) begin
          $error("col%0d_color: expected %04h, got %04h", c, exp.colour[c], got.colour[c]);
          mismatches++;
        end
      end
      if (got.last_row !== exp.last_row) begin
        $error("last_row: expected %0b, got %0b", exp.last_row, got.last_row);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  int   cycle_count = 0;
  bit   src_gaps;
  bit   sink_stalls;

  glyph_row_scoreboard rows_sb;

  tcgr_in_if  char_ch ();
  tcgr_out_if row_ch ();
  tcgr_cfg_if reg_ch ();

  text_cell_glyph_rasterizer_top #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (char_ch),
    .out_o (row_ch),
    .cfg_i (reg_ch)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("text_cell_glyph_rasterizer_top_tb: done, errors");
      $finish;
    end
  end

  task automatic send_char(logic [CodeW-1:0] code, logic [CellCoordW-1:0] cx,
                           logic [CellCoordW-1:0] cy);
    int gap;
    gap = src_gaps ? $urandom_range(0, MaxWait) : 0;
    if (gap > 0) begin
      char_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    char_ch.valid     <= 1'b1;
    char_ch.char_code <= code;
    char_ch.cell_x    <= cx;
    char_ch.cell_y    <= cy;
    do @(posedge clk_i); while (!char_ch.ready);
    rows_sb.draw_cell(code, cx, cy);
  endtask

  task automatic send_random_char();
    logic [CodeW-1:0]      code;
    logic [CellCoordW-1:0] cx;
    logic [CellCoordW-1:0] cy;
    if ($urandom_range(0, 9) < 6) code = ShadeChars[$urandom_range(0, GlyphCount - 1)];
    else code = CodeW'($urandom);
    cx = CellCoordW'($urandom);
    if (LastOnRow < 31 && $urandom_range(0, 9) < 2) begin
      cy = CellCoordW'($urandom_range(LastOnRow + 1, 31));
    end else begin
      cy = CellCoordW'($urandom_range(0, LastOnRow));
    end
    send_char(code, cx, cy);
  endtask

  // stops the character stream and waits for every awaited row
  task automatic wait_rows_drained();
    char_ch.valid <= 1'b0;
    do @(posedge clk_i); while (rows_sb.awaited_rows.size() != 0);
  endtask

  task automatic reg_write(logic [CfgIdxW-1:0] idx, logic [ColorW-1:0] data);
    reg_ch.valid <= 1'b1;
    reg_ch.index <= idx;
    reg_ch.data  <= data;
    do @(posedge clk_i); while (!reg_ch.ready);
    rows_sb.write_reg(idx, data);
  endtask

  task automatic program_colours(logic [ColorW-1:0] fg, logic [ColorW-1:0] bg,
                                 bit poke_spare);
    wait_rows_drained();
    repeat (SettleTicks) @(posedge clk_i);
    reg_write(CFG_FOREGROUND, fg);
    reg_write(CFG_BACKGROUND, bg);
    if (poke_spare) begin
      reg_write(CFG_SPARE_LO, ColorW'($urandom));
      reg_write(CFG_SPARE_HI, ColorW'($urandom));
    end
    reg_ch.valid <= 1'b0;
  endtask

  task automatic drain_rows();
    int         hold;
    pixel_row_t got;
    forever begin
      hold = sink_stalls ? $urandom_range(0, MaxWait) : 0;
      if (hold > 0) begin
        row_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      row_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!row_ch.valid);
      got.row_x     = row_ch.row_x;
      got.row_y     = row_ch.row_y;
      got.colour[0] = row_ch.col0_color;
      got.colour[1] = row_ch.col1_color;
      got.colour[2] = row_ch.col2_color;
      got.colour[3] = row_ch.col3_color;
      got.last_row  = row_ch.last_row;
      rows_sb.check_row(got);
    end
  endtask

  initial begin
    logic [ColorW-1:0] fg;
    logic [ColorW-1:0] bg;
    rows_sb = new();
    rst_ni            <= 1'b0;
    char_ch.valid     <= 1'b0;
    char_ch.char_code <= '0;
    char_ch.cell_x    <= '0;
    char_ch.cell_y    <= '0;
    row_ch.ready      <= 1'b0;
    reg_ch.valid      <= 1'b0;
    reg_ch.index      <= CFG_FOREGROUND;
    reg_ch.data       <= '0;
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    fork
      drain_rows();
    join_none

    // directed: reset colours, every glyph, nul, unknown codes, screen edges
    send_char(8'h00, CellCoordW'(0), CellCoordW'(0));
    for (int k = 0; k < GlyphCount; k++) begin
      send_char(ShadeChars[k], CellCoordW'(k * 2), CellCoordW'(k));
    end
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    send_char(8'hFF, CellCoordW'(31), CellCoordW'(LastOnRow));
    send_char(8'h41, CellCoordW'(5), CellCoordW'(31));
    send_char(8'h80, CellCoordW'(31), CellCoordW'(0));
    send_char(ShadeChars[GlyphCount - 1], CellCoordW'(31), CellCoordW'(LastOnRow));
    send_char(ShadeChars[GlyphCount - 2], CellCoordW'(0), CellCoordW'(31));

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin fg = 16'h0000; bg = 16'hFFFF; end
        1: begin fg = 16'hFFFF; bg = 16'hFFFF; end
        2: begin fg = 16'h0000; bg = 16'h0000; end
        3: begin fg = 16'hF800; bg = 16'h07E0; end
        default: begin fg = ColorW'($urandom); bg = ColorW'($urandom); end
      endcase
      program_colours(fg, bg, p == 2 || p == 5);
      src_gaps    = p[0];
      sink_stalls = p[1];
      if (p >= 4) begin
        src_gaps    = 1'($urandom_range(0, 1));
        sink_stalls = 1'($urandom_range(0, 1));
      end
      for (int i = 0; i < PhaseItems; i++) begin
        // hold off until the block has emptied, then resume
        if (i == PhaseItems / 2 && p[0]) wait_rows_drained();
        send_random_char();
      end
    end

    wait_rows_drained();
    repeat (SettleTicks) @(posedge clk_i);
    if (rows_sb.mismatches == 0 && rows_sb.awaited_rows.size() == 0) begin
      $display("text_cell_glyph_rasterizer_top_tb: done, clean");
    end else begin
      $display("text_cell_glyph_rasterizer_top_tb: done, errors");
    end
    $finish;
  end

endmodule
